>>> design/tap_rate_meter_with_hysteresis_top_assert.svh
// Assertion macros shared by the tap rate meter checker.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef TAP_RATE_METER_WITH_HYSTERESIS_TOP_ASSERT_SVH
`define TAP_RATE_METER_WITH_HYSTERESIS_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tap rate meter check failed");

// Consequent must hold in the cycle after the antecedent.
`define TRM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tap rate meter check failed");

`endif

>>> design/trm_pkg.sv
// Shared types and constants of the tap rate meter.
// No dependencies; used by the top level and the divider.
package trm_pkg;

	typedef enum logic [1:0] {
		REQ_TAP  = 2'd0,
		REQ_POLL = 2'd1,
		REQ_ACK  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		CFG_WINDOW = 2'd0,
		CFG_ON     = 2'd1,
		CFG_OFF    = 2'd2,
		CFG_DECAY  = 2'd3
	} cfg_idx_t;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned RATE_W    = 16;

	localparam int unsigned RATE_SCALE = 10000;
	localparam logic [31:0] RATE_MAX   = 32'd65535;

	localparam logic [15:0] WINDOW_RST = 16'd1000;
	localparam logic [15:0] ON_RST     = 16'd80;
	localparam logic [15:0] OFF_RST    = 16'd50;
	localparam logic [15:0] DECAY_RST  = 16'd1000;

	localparam logic [32:0] MS_FIRST = 33'd100;
	localparam logic [32:0] MS_1E2   = 33'd100;
	localparam logic [32:0] MS_1E3   = 33'd1000;
	localparam logic [32:0] MS_1E4   = 33'd10000;
	localparam logic [32:0] MS_1E5   = 33'd100000;
	localparam logic [32:0] MS_1E6   = 33'd1000000;

	// Next decimal milestone after n. The extra top bit lets the sequence
	// step past the 32-bit range so a saturated total never matches again.
	function automatic logic [32:0] ms_step(input logic [32:0] n);
		logic [32:0] step;
		if (n < MS_1E3) begin
			step = MS_1E2;
		end else if (n < MS_1E4) begin
			step = MS_1E3;
		end else if (n < MS_1E5) begin
			step = MS_1E4;
		end else if (n < MS_1E6) begin
			step = MS_1E5;
		end else begin
			step = MS_1E6;
		end
		return n + step;
	endfunction

endpackage

>>> design/trm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on trm_pkg for the time width.
module trm_div #(
	parameter int unsigned DIV_W = 20
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [DIV_W-1:0]             dividend,
	input  logic [trm_pkg::TIME_W-1:0]   divisor,
	output logic                         done,
	output logic [DIV_W-1:0]             quotient
);

	localparam int unsigned CNT_W = (DIV_W > 1) ? $clog2(DIV_W) : 1;

	logic                         busy_q;
	logic                         done_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [trm_pkg::TIME_W-1:0]   rem_q;
	logic [trm_pkg::TIME_W-1:0]   div_q;
	logic [DIV_W-1:0]             quo_q;
	logic [trm_pkg::TIME_W:0]     trial;
	logic [trm_pkg::TIME_W:0]     diff;
	logic                         ge;
	logic                         last_bit;

	assign trial    = {rem_q, quo_q[DIV_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign diff     = trial - {1'b0, div_q};
	assign last_bit = busy_q && !start && (cnt_q == CNT_W'(DIV_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= last_bit;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// The remainder always stays below the divisor, so its top bit drops.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			div_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[trm_pkg::TIME_W-1:0] : trial[trm_pkg::TIME_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/tap_rate_meter_with_hysteresis_top.sv
// Tap rate meter with hysteresis flag and decimal milestones.
// Depends on trm_pkg and instantiates the trm_div divider.
//
// Usage: items arrive on the in_valid/in_ready channel, one beat per item,
// and each item yields exactly one result beat on out_valid/out_ready.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// while the block is idle; a write takes effect at the same clock edge.
//
// A tap, or a poll that recomputes the rate, passes dispatch, scans the
// history ring one entry per cycle, drains the last read, prepares and runs
// a one-bit-per-cycle divider, updates the flag and loads the result.
// With fewer than two taps in the window the divider is skipped. A poll that
// does not recompute, or an acknowledge, goes from dispatch through the flag
// update to the output; an unused code goes from dispatch to the output.
// The block holds one item at a time: in_ready is high only when idle, from
// the cycle after the result loads; no new item is taken before then.
// The finished result sits in an output register, so the next item is taken
// while the receiver stalls; that item then waits before its result loads.
// Reset clears all counters, the rate, the flag, the milestone and the
// valid bits of the history memory, and restores the register defaults.
module tap_rate_meter_with_hysteresis_top #(
	parameter int unsigned HISTORY_DEPTH    = 16,
	parameter int unsigned POLL_INTERVAL_MS = 100
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       req_type,
	input  logic                             is_left,
	input  logic [31:0]                      now_ms,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [15:0]                      rate_x10,
	output logic                             fast_flag,
	output logic [31:0]                      total_count,
	output logic [31:0]                      left_count,
	output logic [31:0]                      right_count,
	output logic [31:0]                      milestone_value,
	output logic                             milestone_new,
	input  logic                             cfg_we,
	input  logic [trm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [trm_pkg::CFG_W-1:0]        cfg_data
);

	localparam int unsigned AW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned DIV_W = $clog2((HISTORY_DEPTH - 1) * trm_pkg::RATE_SCALE + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_DRAIN,
		S_PREP,
		S_DIV,
		S_FLAG,
		S_OUT
	} state_t;

	state_t                state_q;
	trm_pkg::req_t         req_q;
	logic                  left_q;
	logic [31:0]           now_q;

	logic [15:0]           cfg_window_q;
	logic [15:0]           cfg_on_q;
	logic [15:0]           cfg_off_q;
	logic [15:0]           cfg_decay_q;

	logic [31:0]           mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] vld_q;
	logic [AW-1:0]         wr_slot_q;
	logic [AW-1:0]         scan_idx_q;
	logic                  rd_en_s1;
	logic                  rd_vld_s1;
	logic [31:0]           rd_data_s1;
	logic [CW-1:0]         scan_cnt_q;
	logic [31:0]           oldest_q;

	logic [15:0]           rate_q;
	logic                  fast_q;
	logic [31:0]           last_high_q;
	logic [31:0]           last_poll_q;
	logic [31:0]           total_q;
	logic [31:0]           left_cnt_q;
	logic [31:0]           right_cnt_q;
	logic [31:0]           pending_q;
	logic [32:0]           next_ms_q;
	logic                  fresh_q;

	logic                  div_start_q;
	logic [DIV_W-1:0]      dividend_q;
	logic [31:0]           span_q;
	logic                  div_done;
	logic [DIV_W-1:0]      div_quo;
	logic [31:0]           quo_ext;

	logic                  out_valid_q;
	logic [15:0]           out_rate_q;
	logic                  out_fast_q;
	logic [31:0]           out_total_q;
	logic [31:0]           out_left_q;
	logic [31:0]           out_right_q;
	logic [31:0]           out_pending_q;
	logic                  out_fresh_q;

	logic [31:0]           total_inc;
	logic [31:0]           scan_t;
	logic                  scan_hit;
	logic                  mem_we;
	logic                  span_ok;
	logic                  out_load;

	assign total_inc = (total_q == '1) ? total_q : total_q + 32'd1;
	assign scan_t    = rd_vld_s1 ? rd_data_s1 : 32'd0;
	assign scan_hit  = (scan_t != 32'd0) && ((now_q - scan_t) <= 32'(cfg_window_q));
	assign mem_we    = (state_q == S_DISPATCH) && (req_q == trm_pkg::REQ_TAP);
	assign quo_ext   = 32'(div_quo);
	assign span_ok   = (scan_cnt_q >= CW'(2)) && (oldest_q < now_q);
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	trm_div #(
		.DIV_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (dividend_q),
		.divisor  (span_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// History memory; an entry without its valid bit reads as empty.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_slot_q] <= now_q;
		end
		rd_data_s1 <= mem[scan_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_window_q <= trm_pkg::WINDOW_RST;
			cfg_on_q     <= trm_pkg::ON_RST;
			cfg_off_q    <= trm_pkg::OFF_RST;
			cfg_decay_q  <= trm_pkg::DECAY_RST;
		end else if (cfg_we) begin
			case (trm_pkg::cfg_idx_t'(cfg_index))
				trm_pkg::CFG_WINDOW: cfg_window_q <= cfg_data;
				trm_pkg::CFG_ON:     cfg_on_q     <= cfg_data;
				trm_pkg::CFG_OFF:    cfg_off_q    <= cfg_data;
				trm_pkg::CFG_DECAY:  cfg_decay_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_q       <= trm_pkg::REQ_TAP;
			left_q      <= 1'b0;
			now_q       <= '0;
			vld_q       <= '0;
			wr_slot_q   <= '0;
			scan_idx_q  <= '0;
			rd_en_s1    <= 1'b0;
			rd_vld_s1   <= 1'b0;
			scan_cnt_q  <= '0;
			oldest_q    <= '0;
			rate_q      <= '0;
			fast_q      <= 1'b0;
			last_high_q <= '0;
			last_poll_q <= '0;
			total_q     <= '0;
			left_cnt_q  <= '0;
			right_cnt_q <= '0;
			pending_q   <= '0;
			next_ms_q   <= trm_pkg::MS_FIRST;
			fresh_q     <= 1'b0;
			div_start_q <= 1'b0;
			dividend_q  <= '0;
			span_q      <= '0;
			out_valid_q <= 1'b0;
			out_rate_q    <= '0;
			out_fast_q    <= 1'b0;
			out_total_q   <= '0;
			out_left_q    <= '0;
			out_right_q   <= '0;
			out_pending_q <= '0;
			out_fresh_q   <= 1'b0;
		end else begin
			div_start_q <= (state_q == S_PREP) && span_ok;
			rd_en_s1    <= (state_q == S_SCAN);
			rd_vld_s1   <= vld_q[scan_idx_q];
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			// One read result per cycle folds into the count and oldest stamp.
			if (rd_en_s1 && scan_hit) begin
				scan_cnt_q <= scan_cnt_q + CW'(1);
				if (scan_t < oldest_q) begin
					oldest_q <= scan_t;
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= trm_pkg::req_t'(req_type);
						left_q  <= is_left;
						now_q   <= now_ms;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					fresh_q    <= 1'b0;
					scan_idx_q <= '0;
					scan_cnt_q <= '0;
					oldest_q   <= now_q;
					case (req_q)
						trm_pkg::REQ_TAP: begin
							total_q <= total_inc;
							if (left_q) begin
								if (left_cnt_q != '1) left_cnt_q <= left_cnt_q + 32'd1;
							end else begin
								if (right_cnt_q != '1) right_cnt_q <= right_cnt_q + 32'd1;
							end
							vld_q[wr_slot_q] <= 1'b1;
							wr_slot_q <= (wr_slot_q == AW'(HISTORY_DEPTH - 1)) ?
								'0 : wr_slot_q + AW'(1);
							// The milestone sequence advances even when one is
							// already pending, so a skipped value is never revisited.
							if ({1'b0, total_inc} == next_ms_q) begin
								next_ms_q <= trm_pkg::ms_step(next_ms_q);
								if (pending_q == '0) begin
									pending_q <= total_inc;
									fresh_q   <= 1'b1;
								end
							end
							state_q <= S_SCAN;
						end
						trm_pkg::REQ_POLL: begin
							if ((now_q - last_poll_q) >= 32'(POLL_INTERVAL_MS)) begin
								last_poll_q <= now_q;
								state_q     <= S_SCAN;
							end else begin
								state_q <= S_FLAG;
							end
						end
						trm_pkg::REQ_ACK: begin
							pending_q <= '0;
							state_q   <= S_FLAG;
						end
						default: begin
							state_q <= S_OUT;
						end
					endcase
				end
				S_SCAN: begin
					if (scan_idx_q == AW'(HISTORY_DEPTH - 1)) begin
						state_q <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + AW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					if (span_ok) begin
						dividend_q  <= DIV_W'(32'(scan_cnt_q - CW'(1)) *
							32'(trm_pkg::RATE_SCALE));
						span_q      <= now_q - oldest_q;
						state_q     <= S_DIV;
					end else begin
						rate_q  <= '0;
						state_q <= S_FLAG;
					end
				end
				S_DIV: begin
					if (div_done) begin
						rate_q  <= (quo_ext > trm_pkg::RATE_MAX) ?
							trm_pkg::RATE_MAX[15:0] : quo_ext[15:0];
						state_q <= S_FLAG;
					end
				end
				S_FLAG: begin
					if (rate_q >= cfg_on_q) begin
						last_high_q <= now_q;
						fast_q      <= 1'b1;
					end else if (fast_q && (rate_q < cfg_off_q) &&
							((now_q - last_high_q) >= 32'(cfg_decay_q))) begin
						fast_q <= 1'b0;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_rate_q    <= rate_q;
						out_fast_q    <= fast_q;
						out_total_q   <= total_q;
						out_left_q    <= left_cnt_q;
						out_right_q   <= right_cnt_q;
						out_pending_q <= pending_q;
						out_fresh_q   <= fresh_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign rate_x10        = out_rate_q;
	assign fast_flag       = out_fast_q;
	assign total_count     = out_total_q;
	assign left_count      = out_left_q;
	assign right_count     = out_right_q;
	assign milestone_value = out_pending_q;
	assign milestone_new   = out_fresh_q;

endmodule

>>> design/trm_chk.sv
// Port-level checker for the tap rate meter, bound to the top level.
// Depends on the assertion macros in tap_rate_meter_with_hysteresis_top_assert.svh.
`include "tap_rate_meter_with_hysteresis_top_assert.svh"

module trm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] rate_x10,
	input logic [31:0] total_count,
	input logic [31:0] left_count,
	input logic [31:0] right_count,
	input logic [31:0] milestone_value,
	input logic        milestone_new
);

	// One item in flight: the block closes its input right after a beat.
	`TRM_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

	// A freshly latched milestone is never the empty value.
	`TRM_ASSERT_SAME(a_fresh_nonzero, out_valid && milestone_new, milestone_value != 32'd0)

	// The total saturates last, so it bounds each side counter.
	`TRM_ASSERT_SAME(a_total_bounds, out_valid,
		(total_count >= left_count) && (total_count >= right_count))

	// A stalled result keeps its payload.
	`TRM_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready,
		out_valid && $stable(rate_x10) && $stable(total_count))

endmodule

bind tap_rate_meter_with_hysteresis_top trm_chk u_trm_chk (.*);
